// ===== src/mts_pkg.sv =====
// ----------------------------------------------------------------------------
// mts_pkg
// Shared constants and types for the min-tracking stack: sizes, operation
// codes, status codes and controller states.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ENTRY_W     = 2 * DATA_W;

  typedef enum logic [1:0] {
    ACT_PUSH = 2'd0,
    ACT_POP  = 2'd1,
    ACT_PEEK = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_FILL = 1'b1
  } state_t;

endpackage

// ===== src/mts_ram.sv =====
// ----------------------------------------------------------------------------
// mts_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module mts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/min_tracking_stack.sv =====
// ----------------------------------------------------------------------------
// min_tracking_stack
// LIFO stack of signed 32-bit values that reports the top entry and the
// least value held after every push, pop or peek beat.
// ----------------------------------------------------------------------------
// Result timing: the result strobe is registered at the accepting edge, or,
//   for a pop that leaves entries behind, from S_FILL (the new top comes from RAM).
// Throughput: 1 beat per cycle while not busy; such a pop holds busy in S_FILL
//   while the entry under the old top, read through the single RAM read port, is loaded.
// Reset: fill count and controller clear; RAM contents stay
//   undefined and are never used before being written. No clearing pass.
// The receiver cannot stall: each result is on the ports for one cycle only.
// ----------------------------------------------------------------------------
module min_tracking_stack (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         action,
  input  logic signed [mts_pkg::DATA_W-1:0]  value,
  output logic                               done,
  output logic signed [mts_pkg::DATA_W-1:0]  top_value,
  output logic signed [mts_pkg::DATA_W-1:0]  min_value,
  output logic                               is_empty,
  output logic [1:0]                         status
);

  import mts_pkg::*;

  // Top entry lives in registers; entries below it live in RAM, entry i at
  // address i, so the RAM holds count-1 valid words.
  state_t                    state, state_next;
  logic [CNT_W-1:0]          count, count_next;
  logic signed [DATA_W-1:0]  top_val, top_val_next;
  logic signed [DATA_W-1:0]  top_min, top_min_next;

  logic                      accept;
  logic                      res_valid;
  status_t                   res_status;

  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_waddr;
  logic [ENTRY_W-1:0]        ram_wdata;
  logic [ADDR_W-1:0]         ram_raddr;
  logic [ENTRY_W-1:0]        ram_rdata;

  assign busy   = (state == S_FILL);
  assign accept = start && !busy;

  mts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STACK_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state, stack update and result selection.
  always_comb begin
    state_next   = state;
    count_next   = count;
    top_val_next = top_val;
    top_min_next = top_min;
    res_valid    = 1'b0;
    res_status   = STAT_OK;
    ram_we       = 1'b0;
    ram_waddr    = ADDR_W'(count - CNT_W'(1));
    ram_wdata    = {top_val, top_min};
    ram_raddr    = ADDR_W'(count - CNT_W'(2));

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority if (action == ACT_PUSH) begin
            res_valid = 1'b1;
            if (count == CNT_W'(STACK_DEPTH)) begin
              // Full: drop the push, report the untouched top.
              res_status = STAT_OVERFLOW;
            end else begin
              // Spill the old top below the new one.
              ram_we       = (count != '0);
              top_val_next = value;
              top_min_next = ((count != '0) && (value > top_min)) ? top_min : value;
              count_next   = count + CNT_W'(1);
            end
          end else if (action == ACT_POP) begin
            if (count == '0) begin
              res_valid  = 1'b1;
              res_status = STAT_UNDERFLOW;
            end else if (count == CNT_W'(1)) begin
              res_valid  = 1'b1;
              count_next = '0;
            end else begin
              // Fetch the entry under the top; result follows the read.
              count_next = count - CNT_W'(1);
              state_next = S_FILL;
            end
          end else begin
            // Peek, and the unused code, report the current top.
            res_valid = 1'b1;
          end
        end
      end
      S_FILL: begin
        top_val_next = ram_rdata[ENTRY_W-1:DATA_W];
        top_min_next = ram_rdata[DATA_W-1:0];
        res_valid    = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= res_valid;
    end
  end

  // Payload registers: hold the top and the result beat.
  always_ff @(posedge clk) begin
    top_val <= top_val_next;
    top_min <= top_min_next;
    if (count_next == '0) begin
      top_value <= '1;
      min_value <= '1;
      is_empty  <= 1'b1;
    end else begin
      top_value <= top_val_next;
      min_value <= top_min_next;
      is_empty  <= 1'b0;
    end
    status <= res_status;
  end

  // Assertions
  a_fill_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("fill state lasted more than one cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("fill count beyond stack depth");

  a_quick_result: assert property (@(posedge clk) disable iff (rst)
    (accept && (action != ACT_POP || count < CNT_W'(2))) |=> done)
    else $error("missing result beat after accepted item");

  a_fill_result: assert property (@(posedge clk) disable iff (rst)
    busy |=> done)
    else $error("missing result beat after RAM fill");

  a_empty_words: assert property (@(posedge clk) disable iff (rst)
    (done && is_empty) |-> (top_value == '1 && min_value == '1))
    else $error("empty result without all-ones words");

  a_min_order: assert property (@(posedge clk) disable iff (rst)
    (done && !is_empty) |-> (min_value <= top_value))
    else $error("reported minimum exceeds top value");

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for min_tracking_stack: drives push, pop and peek beats
// with random gaps, tracks a shadow stack of values and running minimums, and
// compares every result strobe against the predicted top, minimum, empty flag
// and status.
// ----------------------------------------------------------------------------
module testbench;

  import mts_pkg::*;

  // Action code 3 is not assigned; the block treats it as a peek.
  localparam logic [1:0] ACT_SPARE = 2'd3;

  localparam logic signed [DATA_W-1:0] WORD_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] WORD_MIN   = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] EMPTY_WORD = -32'sd1;

  // Direction of the random walk through the stack depth.
  typedef enum logic { WALK_UP, WALK_DOWN } walk_t;

  typedef struct {
    logic signed [DATA_W-1:0] top;
    logic signed [DATA_W-1:0] least;
    logic                     empty;
    status_t                  st;
  } stack_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [1:0]               action = ACT_PEEK;
  logic signed [DATA_W-1:0] value = '0;
  logic                     busy;
  logic                     done;
  logic signed [DATA_W-1:0] top_value;
  logic signed [DATA_W-1:0] min_value;
  logic                     is_empty;
  logic [1:0]               status;

  // Shadow copy of the stack: each entry holds its value and the minimum
  // of the stack as of that entry.
  logic signed [DATA_W-1:0] shadow_vals [STACK_DEPTH];
  logic signed [DATA_W-1:0] shadow_mins [STACK_DEPTH];
  int                       shadow_fill = 0;

  // Results predicted at accept time, oldest first.
  stack_result_t            pending_results [$];
  int                       error_count = 0;

  min_tracking_stack dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .action    (action),
    .value     (value),
    .done      (done),
    .top_value (top_value),
    .min_value (min_value),
    .is_empty  (is_empty),
    .status    (status)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("[%0t] mismatch on %s: got %0d (0x%08h), want %0d (0x%08h)",
             $time, what, $signed(got), got, $signed(want), want);
    error_count++;
  endtask

  // Update the shadow stack for one accepted beat and queue the result
  // the block must produce for it.
  task automatic apply_stack_op(input logic [1:0] act, input logic signed [DATA_W-1:0] data);
    stack_result_t            res;
    logic signed [DATA_W-1:0] run_min;
    res.st = STAT_OK;
    case (act)
      ACT_PUSH: begin
        if (shadow_fill >= STACK_DEPTH) begin
          res.st = STAT_OVERFLOW;
        end else begin
          run_min = data;
          if (shadow_fill > 0 && data > shadow_mins[shadow_fill-1]) begin
            run_min = shadow_mins[shadow_fill-1];
          end
          shadow_vals[shadow_fill] = data;
          shadow_mins[shadow_fill] = run_min;
          shadow_fill++;
        end
      end
      ACT_POP: begin
        if (shadow_fill == 0) begin
          res.st = STAT_UNDERFLOW;
        end else begin
          shadow_fill--;
        end
      end
      default: ;
    endcase
    if (shadow_fill == 0) begin
      res.top   = EMPTY_WORD;
      res.least = EMPTY_WORD;
      res.empty = 1'b1;
    end else begin
      res.top   = shadow_vals[shadow_fill-1];
      res.least = shadow_mins[shadow_fill-1];
      res.empty = 1'b0;
    end
    pending_results.push_back(res);
  endtask

  // Present one beat and hold it until the block takes it. Leave start high
  // on return so a back-to-back beat needs no second assignment this step.
  task automatic send_beat(input logic [1:0] act, input logic signed [DATA_W-1:0] data);
    start  <= 1'b1;
    action <= act;
    value  <= data;
    do @(posedge clk); while (busy);
    apply_stack_op(act, data);
  endtask

  // Idle the sender for a random gap: mostly none, sometimes short, rarely long.
  task automatic idle_sender();
    int pick;
    int gap;
    pick = $urandom_range(0, 99);
    if (pick < 65)      gap = 0;
    else if (pick < 95) gap = $urandom_range(1, 3);
    else                gap = $urandom_range(8, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start and hold off until every predicted result has arrived.
  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Pick a push value: mostly anything, often a narrow band so equal values
  // and ties with the running minimum occur, sometimes an extreme.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: pick_value = $urandom;
      4, 5, 6:    pick_value = $signed($urandom_range(0, 16)) - 8;
      7: begin
        case ($urandom_range(0, 3))
          0:       pick_value = WORD_MAX;
          1:       pick_value = WORD_MIN;
          2:       pick_value = EMPTY_WORD;
          default: pick_value = '0;
        endcase
      end
      default: begin
        // Repeat the current minimum to exercise the tie case.
        pick_value = (shadow_fill > 0) ? shadow_mins[shadow_fill-1] : $urandom;
      end
    endcase
  endfunction

  // Compare each strobed result with the oldest prediction.
  always @(posedge clk) begin
    stack_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", top_value, '0);
      end else begin
        want = pending_results.pop_front();
        if (top_value !== want.top)   report_mismatch("top_value", top_value, want.top);
        if (min_value !== want.least) report_mismatch("min_value", min_value, want.least);
        if (is_empty !== want.empty) begin
          report_mismatch("is_empty", DATA_W'(is_empty), DATA_W'(want.empty));
        end
        if (status !== want.st) begin
          report_mismatch("status", DATA_W'(status), DATA_W'(want.st));
        end
      end
    end
  end

  // Empty-stack behavior, extremes of the value range, every action code,
  // ties with the minimum and popping back to empty.
  task automatic test_directed();
    send_beat(ACT_POP, '0);          // underflow on an empty stack
    send_beat(ACT_PEEK, '0);
    send_beat(ACT_SPARE, 32'sh1234_5678);
    send_beat(ACT_PUSH, WORD_MAX);
    idle_sender();
    send_beat(ACT_PUSH, 32'sd5);
    send_beat(ACT_PUSH, 32'sd5);     // equal to the current minimum
    send_beat(ACT_PUSH, 32'sd9);     // above the minimum, min holds
    send_beat(ACT_PUSH, EMPTY_WORD); // a real -1 while not empty
    send_beat(ACT_PUSH, WORD_MIN);
    send_beat(ACT_PUSH, WORD_MAX);
    send_beat(ACT_PEEK, WORD_MIN);
    send_beat(ACT_SPARE, '0);
    idle_sender();
    send_beat(ACT_POP, WORD_MAX);
    send_beat(ACT_POP, '0);
    send_beat(ACT_POP, '0);
    send_beat(ACT_PEEK, '0);
    send_beat(ACT_POP, '0);
    send_beat(ACT_POP, '0);
    send_beat(ACT_POP, '0);          // one entry left
    send_beat(ACT_POP, '0);          // back to empty
    send_beat(ACT_PUSH, '0);
    send_beat(ACT_POP, '0);
    wait_for_results();
  endtask

  // Fill to the top, push into a full stack, then pop everything back out.
  task automatic test_full_stack();
    for (int i = 0; i < STACK_DEPTH; i++) begin
      send_beat(ACT_PUSH, pick_value());
      idle_sender();
    end
    send_beat(ACT_PUSH, WORD_MIN);   // dropped: must not become the minimum
    send_beat(ACT_PUSH, $urandom);
    send_beat(ACT_PEEK, '0);
    send_beat(ACT_POP, '0);
    send_beat(ACT_PUSH, WORD_MIN);   // room again, so this one lands
    while (shadow_fill > 0) begin
      send_beat(ACT_POP, $urandom);
      idle_sender();
    end
    send_beat(ACT_POP, '0);
    wait_for_results();
  endtask

  // Random walk through the depth: phases lean toward pushes or pops so the
  // stack swings between full and empty, with peeks and spare codes mixed in.
  task automatic test_random_walk(input int beats);
    walk_t           lean;
    int              pick;
    logic [1:0]      act;
    lean = WALK_UP;
    for (int n = 0; n < beats; n++) begin
      if (n % 200 == 199) begin
        lean = (lean == WALK_UP) ? WALK_DOWN : WALK_UP;
      end
      // Hold off once mid-run until the block has answered everything.
      if (n == beats / 2) begin
        wait_for_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < 2)       act = ACT_SPARE;
      else if (pick < 8)  act = ACT_PEEK;
      else if (pick < 8 + ((lean == WALK_UP) ? 70 : 25)) act = ACT_PUSH;
      else                act = ACT_POP;
      send_beat(act, (act == ACT_PUSH) ? pick_value() : logic'($urandom) ? $urandom : '0);
      idle_sender();
    end
    wait_for_results();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_stack();
    test_random_walk(1400);
    start <= 1'b0;
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch("results never seen", pending_results.size(), '0);
    end
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
src/mts_pkg.sv
src/mts_ram.sv
src/min_tracking_stack.sv
sim/testbench.sv
